// ----- rtl/core/mpbf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpbf_pkg: shared types and codes of the multi pipe byte FIFO
// Item and result structs, command and status codes, controller commands.
// ----------------------------------------------------------------------------
package mpbf_pkg;

	typedef enum logic [1:0] {
		CMD_CREATE = 2'd0,
		CMD_WRITE  = 2'd1,
		CMD_READ   = 2'd2,
		CMD_UNUSED = 2'd3
	} command_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_NO_PIPE = 3'd1,
		ST_FULL    = 3'd2,
		ST_EMPTY   = 3'd3,
		ST_NO_SLOT = 3'd4
	} status_t;

	localparam logic [15:0] PROGRESS_MAX = 16'hFFFF;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  pipe_number;
		logic [14:0] owner;
		logic [7:0]  data_byte;
		logic        last_of_call;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  new_id;
		logic [7:0]  read_byte;
		logic [12:0] fill_level;
		logic [15:0] moved_in_call;
		logic [31:0] running_total;
	} result_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;   // capture item, launch slot record read
		logic exec;   // decide, update state, launch byte access
		logic reply;  // register the result and pulse the strobe
	} ctl_cmd_t;

endpackage : mpbf_pkg
`default_nettype wire

// ----- rtl/core/mpbf_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpbf_ram: generic single write port, single read port RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mpbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule : mpbf_ram
`default_nettype wire

// ----- rtl/core/mpbf_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpbf_ctrl: item sequencer
// Walks each accepted item through execute and reply, one item at a time.
// ----------------------------------------------------------------------------
module mpbf_ctrl
	import mpbf_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	output ctl_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_REPLY
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:  state_q <= start ? S_EXEC : S_IDLE;
				S_EXEC:  state_q <= S_REPLY;
				S_REPLY: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign cmd.load  = start && (state_q == S_IDLE);
	assign cmd.exec  = (state_q == S_EXEC);
	assign cmd.reply = (state_q == S_REPLY);

endmodule : mpbf_ctrl
`default_nettype wire

// ----- rtl/core/mpbf_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpbf_dp: pipe datapath
// Slot record RAM, byte store RAM, claim counter, call progress, result reg.
// ----------------------------------------------------------------------------
module mpbf_dp
	import mpbf_pkg::*;
#(
	parameter int PIPE_COUNT = 8,
	parameter int PIPE_DEPTH = 256
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire ctl_cmd_t cmd,
	input  wire item_t    item,
	output result_t       result,
	output logic          result_valid
);

	localparam int SW = (PIPE_COUNT > 1) ? $clog2(PIPE_COUNT) : 1;
	localparam int CW = $clog2(PIPE_COUNT + 1);
	localparam int IW = $clog2(PIPE_DEPTH);
	localparam int FW = $clog2(PIPE_DEPTH + 1);
	localparam int BYTES = PIPE_COUNT * PIPE_DEPTH;
	localparam int BW = (BYTES > 1) ? $clog2(BYTES) : 1;
	localparam int RW = 15 + IW + IW + FW + 32 + 32;

	localparam logic [IW-1:0] IDX_LAST = IW'(PIPE_DEPTH - 1);
	localparam logic [FW-1:0] FILL_MAX = FW'(PIPE_DEPTH);
	localparam logic [BW-1:0] DEPTH_B  = BW'(PIPE_DEPTH);

	item_t         item_q;
	logic [CW-1:0] claimed_q;
	logic [15:0]   progress_q;
	result_t       res_s1;
	logic          rd_ok_s1;
	result_t       res_out;

	// slot record fields
	logic [14:0]   rec_owner;
	logic [IW-1:0] rec_head, rec_tail;
	logic [FW-1:0] rec_fill;
	logic [31:0]   rec_wt, rec_rt;
	logic [RW-1:0] rec_rdata, rec_wdata;
	logic          rec_we;
	logic [SW-1:0] rec_waddr, rec_raddr;

	logic          byte_we;
	logic [BW-1:0] byte_waddr, byte_raddr;
	logic [7:0]    byte_rdata;

	// decode
	logic          id_valid, is_create, is_write, is_read, create_ok, wr_ok, rd_ok, moved;
	logic [SW-1:0] slot;
	logic [BW-1:0] base;
	logic [IW-1:0] head_nxt, tail_nxt;
	logic [FW-1:0] fill_nxt;
	logic [31:0]   wt_nxt, rt_nxt;
	logic [15:0]   progress_nxt;
	result_t       res_d;

	assign {rec_owner, rec_head, rec_tail, rec_fill, rec_wt, rec_rt} = rec_rdata;

	// launch the record read straight from the item port at accept
	assign rec_raddr = SW'(item.pipe_number - 8'd1);

	assign slot      = SW'(item_q.pipe_number - 8'd1);
	assign id_valid  = (item_q.pipe_number != 8'd0) &&
	                   ({1'b0, item_q.pipe_number} <= 9'(claimed_q));
	assign is_create = (item_q.command == CMD_CREATE);
	assign is_write  = (item_q.command == CMD_WRITE) && id_valid;
	assign is_read   = (item_q.command == CMD_READ) && id_valid;
	assign create_ok = is_create && (claimed_q < CW'(PIPE_COUNT));
	assign wr_ok     = is_write && (rec_fill != FILL_MAX);
	assign rd_ok     = is_read && (rec_fill != '0);
	assign moved     = wr_ok || rd_ok;

	assign base       = BW'(slot) * DEPTH_B;
	assign byte_waddr = base + BW'(rec_head);
	assign byte_raddr = base + BW'(rec_tail);
	assign byte_we    = cmd.exec && wr_ok;

	always_comb begin
		head_nxt = (rec_head == IDX_LAST) ? '0 : rec_head + IW'(1);
		tail_nxt = (rec_tail == IDX_LAST) ? '0 : rec_tail + IW'(1);
		fill_nxt = rec_fill;
		wt_nxt   = rec_wt;
		rt_nxt   = rec_rt;
		if (wr_ok) begin
			fill_nxt = rec_fill + FW'(1);
			wt_nxt   = rec_wt + 32'd1;
		end
		if (rd_ok) begin
			fill_nxt = rec_fill - FW'(1);
			rt_nxt   = rec_rt + 32'd1;
		end
		progress_nxt = (moved && progress_q != PROGRESS_MAX) ? progress_q + 16'd1
		                                                       : progress_q;
	end

	// record write: fresh record (owner kept, all else zero) on create, updated pointers, fill and totals on a move
	always_comb begin
		rec_we    = cmd.exec && (create_ok || moved);
		rec_waddr = create_ok ? SW'(claimed_q) : slot;
		if (create_ok) begin
			rec_wdata = {item_q.owner, {(RW - 15){1'b0}}};
		end else begin
			rec_wdata = {rec_owner, wr_ok ? head_nxt : rec_head,
			             rd_ok ? tail_nxt : rec_tail, fill_nxt, wt_nxt, rt_nxt};
		end
	end

	always_comb begin
		res_d               = '0;
		res_d.status        = ST_NO_PIPE;
		res_d.moved_in_call = progress_nxt;
		if (is_create) begin
			res_d.status = create_ok ? ST_OK : ST_NO_SLOT;
			res_d.new_id = create_ok ? 8'(claimed_q) + 8'd1 : 8'd0;
		end else if (is_write) begin
			res_d.status        = wr_ok ? ST_OK : ST_FULL;
			res_d.fill_level    = 13'(fill_nxt);
			res_d.running_total = wt_nxt;
		end else if (is_read) begin
			res_d.status        = rd_ok ? ST_OK : ST_EMPTY;
			res_d.fill_level    = 13'(fill_nxt);
			res_d.running_total = rt_nxt;
		end
	end

	// merge the popped byte into the staged result
	always_comb begin
		res_out           = res_s1;
		res_out.read_byte = rd_ok_s1 ? byte_rdata : 8'd0;
	end

	mpbf_ram #(.WIDTH(RW), .DEPTH(PIPE_COUNT)) u_rec_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (rec_waddr),
		.wdata (rec_wdata),
		.raddr (rec_raddr),
		.rdata (rec_rdata)
	);

	mpbf_ram #(.WIDTH(8), .DEPTH(BYTES)) u_byte_ram (
		.clk   (clk),
		.we    (byte_we),
		.waddr (byte_waddr),
		.wdata (item_q.data_byte),
		.raddr (byte_raddr),
		.rdata (byte_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.exec) begin
			res_s1   <= res_d;
			rd_ok_s1 <= rd_ok;
		end
		if (cmd.reply) begin
			result <= res_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			claimed_q    <= '0;
			progress_q   <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.reply;
			if (cmd.exec) begin
				if (create_ok) begin
					claimed_q <= claimed_q + CW'(1);
				end
				progress_q <= item_q.last_of_call ? 16'd0 : progress_nxt;
			end
		end
	end

endmodule : mpbf_dp
`default_nettype wire

// ----- rtl/core/multi_pipe_byte_fifo_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_pipe_byte_fifo_core: bank of circular byte pipes
// Create, write-byte and read-byte commands on up to PIPE_COUNT pipes.
// ----------------------------------------------------------------------------
//
//  channel   ports                       transfer when
//  --------  --------------------------  -------------------------------
//  item      start, busy, item           start high and busy low
//  result    result_valid, result        result_valid high (one cycle)
//
//  Each item passes through accept, execute and reply. The slot record
//  RAM has a registered read, so the record fetched at accept is used in
//  execute; the byte store read launched in execute lands in reply.
//  The result strobe rises the cycle after reply; busy is low then, so the
//  next item may be accepted in that same cycle.
//  Reset clears the claim count and call progress; slot records need no
//  clearing since a slot is written whole when it is created.
//  The receiver cannot stall: results are never held back.
//
module multi_pipe_byte_fifo_core
	import mpbf_pkg::*;
#(
	parameter int PIPE_COUNT = 8,
	parameter int PIPE_DEPTH = 256
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	output logic       busy,
	input  wire item_t item,
	output logic       result_valid,
	output result_t    result
);

	ctl_cmd_t cmd;

	// Sequence accepted items; one in flight at a time
	mpbf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	// Hold pipe state and build each result
	mpbf_dp #(
		.PIPE_COUNT (PIPE_COUNT),
		.PIPE_DEPTH (PIPE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.item         (item),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule : multi_pipe_byte_fifo_core
`default_nettype wire

// ----- tb/multi_pipe_byte_fifo_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_pipe_byte_fifo_core_test: self-checking bench for the byte pipe bank
// Drives create, write and read commands through the start/busy port and
// checks every strobed result against a cycle-free model of the pipe bank.
// ----------------------------------------------------------------------------
module multi_pipe_byte_fifo_core_test;
	import mpbf_pkg::*;

	localparam int PIPE_COUNT = 8;
	localparam int PIPE_DEPTH = 256;
	localparam int SHOWN_MISMATCHES = 100;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    result_valid;
	result_t result;

	// Pipe bank as the bench sees it; updated when a transfer is accepted
	logic        pipe_claimed  [PIPE_COUNT];
	logic [14:0] pipe_owner    [PIPE_COUNT];
	int          pipe_head     [PIPE_COUNT];
	int          pipe_tail     [PIPE_COUNT];
	int          pipe_fill     [PIPE_COUNT];
	logic [7:0]  pipe_bytes    [PIPE_COUNT][PIPE_DEPTH];
	logic [31:0] pipe_wr_total [PIPE_COUNT];
	logic [31:0] pipe_rd_total [PIPE_COUNT];
	logic [15:0] call_moved;

	// Results owed by the block, oldest first
	result_t reply_queue [$];

	int n_sent;
	int n_checked;
	int n_errors;
	int status_seen [8];
	int hot_pipe;

	multi_pipe_byte_fifo_core #(
		.PIPE_COUNT(PIPE_COUNT),
		.PIPE_DEPTH(PIPE_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_valid(result_valid),
		.result(result)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// Pipe bank behavior: apply one accepted command and return the
	// result the block must produce for it. The moved count shown is the
	// value before a last-of-call clear.
	// ------------------------------------------------------------------
	function automatic result_t compute_reply(input item_t it);
		result_t r;
		int      s;
		bit      found;
		r = '0;
		r.status = ST_NO_PIPE;
		found = 1'b0;
		s = int'(it.pipe_number) - 1;
		case (command_t'(it.command))
			CMD_CREATE: begin
				// claim the lowest free slot; slots never get released
				r.status = ST_NO_SLOT;
				for (int i = 0; i < PIPE_COUNT; i++) begin
					if (!found && !pipe_claimed[i]) begin
						found = 1'b1;
						pipe_claimed[i] = 1'b1;
						pipe_owner[i] = it.owner;
						r.status = ST_OK;
						r.new_id = 8'(i + 1);
						r.fill_level = 13'(pipe_fill[i]);
					end
				end
			end
			CMD_WRITE: begin
				if (s >= 0 && s < PIPE_COUNT && pipe_claimed[s]) begin
					if (pipe_fill[s] >= PIPE_DEPTH) begin
						r.status = ST_FULL;
					end else begin
						pipe_bytes[s][pipe_head[s]] = it.data_byte;
						pipe_head[s] = (pipe_head[s] + 1) % PIPE_DEPTH;
						pipe_fill[s]++;
						pipe_wr_total[s] = pipe_wr_total[s] + 32'd1;
						if (call_moved != PROGRESS_MAX) call_moved++;
						r.status = ST_OK;
					end
					r.running_total = pipe_wr_total[s];
					r.fill_level = 13'(pipe_fill[s]);
				end
			end
			CMD_READ: begin
				if (s >= 0 && s < PIPE_COUNT && pipe_claimed[s]) begin
					if (pipe_fill[s] == 0) begin
						r.status = ST_EMPTY;
					end else begin
						r.read_byte = pipe_bytes[s][pipe_tail[s]];
						pipe_tail[s] = (pipe_tail[s] + 1) % PIPE_DEPTH;
						pipe_fill[s]--;
						pipe_rd_total[s] = pipe_rd_total[s] + 32'd1;
						if (call_moved != PROGRESS_MAX) call_moved++;
						r.status = ST_OK;
					end
					r.running_total = pipe_rd_total[s];
					r.fill_level = 13'(pipe_fill[s]);
				end
			end
			default: begin
				// unused command: treated as a bad id, nothing changes
			end
		endcase
		r.moved_in_call = call_moved;
		if (it.last_of_call) call_moved = '0;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Random command mix: mostly byte moves on pipes 1 to PIPE_COUNT, with creates,
	// bad ids and the unused command sprinkled in.
	function automatic item_t random_pipe_item(input int write_pct);
		item_t it;
		int    r;
		it.owner = 15'($urandom);
		it.data_byte = 8'($urandom);
		it.last_of_call = ($urandom_range(7) == 0);
		it.pipe_number = 8'($urandom);
		r = $urandom_range(99);
		if (r < 6) begin
			it.command = CMD_CREATE;
		end else if (r < 9) begin
			it.command = CMD_UNUSED;
			it.pipe_number = 8'($urandom_range(1, PIPE_COUNT));
		end else if (r < 13) begin
			it.command = $urandom_range(1) ? CMD_WRITE : CMD_READ;
			it.pipe_number = $urandom_range(1) ? 8'd0 : 8'($urandom_range(PIPE_COUNT + 1, 255));
		end else begin
			it.command = ($urandom_range(99) < write_pct) ? CMD_WRITE : CMD_READ;
			it.pipe_number = $urandom_range(1) ? 8'(hot_pipe) :
				8'($urandom_range(1, PIPE_COUNT));
		end
		return it;
	endfunction

	// Present one command at the falling edge and hold it until accepted.
	// Start stays high on return so back-to-back commands need no gap.
	task automatic send_pipe_item(input item_t it);
		@(negedge clk);
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy !== 1'b0);
		reply_queue.push_back(compute_reply(it));
		n_sent++;
	endtask

	// Drop start for one cycle with junk on the item bus
	task automatic idle_cycle();
		@(negedge clk);
		start <= 1'b0;
		item <= random_pipe_item(50);
	endtask

	// Hold off new commands until every owed result has come back
	task automatic wait_all_replies();
		idle_cycle();
		while (reply_queue.size() != 0) @(posedge clk);
	endtask

	function automatic item_t make_item(input command_t cmd, input int id,
		input logic [14:0] own, input logic [7:0] data, input logic last);
		item_t it;
		it.command = cmd;
		it.pipe_number = 8'(id);
		it.owner = own;
		it.data_byte = data;
		it.last_of_call = last;
		return it;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Bad ids before any pipe exists, first creates, empty reads, field
	// extremes and last-of-call clearing.
	task automatic test_directed_cases();
		send_pipe_item(make_item(CMD_WRITE, 1, 15'd0, 8'h3C, 1'b0));
		send_pipe_item(make_item(CMD_READ, 0, 15'd0, 8'h00, 1'b0));
		send_pipe_item(make_item(CMD_UNUSED, 1, 15'h7FFF, 8'hFF, 1'b1));
		send_pipe_item(make_item(CMD_CREATE, 255, 15'd0, 8'hFF, 1'b0));
		send_pipe_item(make_item(CMD_CREATE, 0, 15'h7FFF, 8'h00, 1'b0));
		send_pipe_item(make_item(CMD_CREATE, 7, 15'($urandom), 8'h5A, 1'b1));
		send_pipe_item(make_item(CMD_READ, 1, 15'd0, 8'h00, 1'b0));
		send_pipe_item(make_item(CMD_WRITE, 1, 15'd0, 8'h00, 1'b0));
		send_pipe_item(make_item(CMD_WRITE, 1, 15'h7FFF, 8'hFF, 1'b0));
		send_pipe_item(make_item(CMD_WRITE, 2, 15'd0, 8'hA5, 1'b1));
		send_pipe_item(make_item(CMD_READ, 1, 15'd0, 8'h00, 1'b0));
		send_pipe_item(make_item(CMD_READ, 1, 15'd0, 8'h00, 1'b1));
		send_pipe_item(make_item(CMD_READ, PIPE_COUNT + 1, 15'd0, 8'h00, 1'b0));
		send_pipe_item(make_item(CMD_WRITE, 255, 15'd0, 8'h11, 1'b0));
		// pipe 4 not yet claimed
		send_pipe_item(make_item(CMD_WRITE, 4, 15'd0, 8'h22, 1'b0));
		send_pipe_item(make_item(CMD_UNUSED, 2, 15'd0, 8'h33, 1'b0));
		send_pipe_item(make_item(CMD_READ, 2, 15'd0, 8'h00, 1'b1));
		send_pipe_item(make_item(CMD_READ, 2, 15'd0, 8'h00, 1'b1));
		wait_all_replies();
	endtask

	// Fill one pipe past its depth, then drain it past empty
	task automatic test_fill_to_full();
		for (int i = 0; i <= PIPE_DEPTH; i++)
			send_pipe_item(make_item(CMD_WRITE, 3, 15'($urandom), 8'($urandom),
				i == PIPE_DEPTH));
		for (int i = 0; i <= PIPE_DEPTH; i++)
			send_pipe_item(make_item(CMD_READ, 3, 15'($urandom), 8'($urandom),
				i == PIPE_DEPTH));
		wait_all_replies();
	endtask

	// Random traffic in phases of different sender idling and write bias
	task automatic test_random_traffic();
		int idle_mix  [4] = '{0, 83, 26, 0};
		int write_mix [4] = '{70, 40, 75, 30};
		for (int p = 0; p < 4; p++) begin
			hot_pipe = p + 2;
			repeat (280) begin
				while ($urandom_range(99) < idle_mix[p]) idle_cycle();
				send_pipe_item(random_pipe_item(write_mix[p]));
			end
			wait_all_replies();
		end
	endtask

	// Claim whatever is left and then ask for more than exists
	task automatic test_slot_exhaustion();
		int free_slots;
		free_slots = 0;
		foreach (pipe_claimed[i])
			if (!pipe_claimed[i]) free_slots++;
		repeat (free_slots + 2)
			send_pipe_item(make_item(CMD_CREATE, $urandom_range(255), 15'($urandom),
				8'($urandom), 1'($urandom)));
		wait_all_replies();
	endtask

	// ------------------------------------------------------------------
	// Result checking: every strobe takes the oldest owed result
	// ------------------------------------------------------------------
	task automatic check_field(input string field, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			n_errors++;
			if (n_errors <= SHOWN_MISMATCHES)
				$display("%0t ns: %s mismatch, expected %0d, actual %0d",
					$time, field, want, got);
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (result_valid === 1'b1) begin
			if (reply_queue.size() == 0) begin
				n_errors++;
				$display("%0t ns: result with none owed, actual status %0d",
					$time, result.status);
			end else begin
				want = reply_queue.pop_front();
				check_field("status", want.status, result.status);
				check_field("new_id", want.new_id, result.new_id);
				check_field("read_byte", want.read_byte, result.read_byte);
				check_field("fill_level", want.fill_level, result.fill_level);
				check_field("moved_in_call", want.moved_in_call, result.moved_in_call);
				check_field("running_total", want.running_total, result.running_total);
				status_seen[want.status]++;
				n_checked++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence: reset once, run the tests in turn, then report
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		call_moved = '0;
		foreach (pipe_claimed[i]) begin
			pipe_claimed[i] = 1'b0;
			pipe_owner[i] = '0;
			pipe_head[i] = 0;
			pipe_tail[i] = 0;
			pipe_fill[i] = 0;
			pipe_wr_total[i] = '0;
			pipe_rd_total[i] = '0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_fill_to_full();
		test_random_traffic();
		test_slot_exhaustion();

		wait_all_replies();
		repeat (8) @(posedge clk);

		$display("covered %0d commands, %0d results checked: ok %0d, no pipe %0d, full %0d,",
			n_sent, n_checked, status_seen[ST_OK], status_seen[ST_NO_PIPE],
			status_seen[ST_FULL]);
		$display("empty %0d, no slot %0d; one pipe ran from empty to full and back",
			status_seen[ST_EMPTY], status_seen[ST_NO_SLOT]);
		if (n_errors == 0 && reply_queue.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Watchdog well beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("timeout with %0d results still owed", reply_queue.size());
		$display("simulation failed");
		$finish;
	end

endmodule
